// File: sv/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and arithmetic helpers for the three-stage
// feedback comb echo unit.
// ----------------------------------------------------------------------------
package cfc_pkg;

   // sample and coefficient widths
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 15;
   localparam int DELAY_W   = 15;

   // delay line geometry: one line per channel per stage
   localparam int MAX_DELAY = 32768;
   localparam int POS_W     = $clog2(MAX_DELAY);
   localparam int CHANNELS  = 2;
   localparam int CH_W      = $clog2(CHANNELS);
   localparam int ADDR_W    = CH_W + POS_W;
   localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;

   // product and rounding
   localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
   localparam int TERM_W    = PROD_W - GAIN_W;
   localparam int SUM_W     = TERM_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (GAIN_W - 1);

   // number of comb stages
   localparam int NUM_STAGES = 3;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // register index codes
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIRST_DELAY  = 3'd0,
      REG_FIRST_GAIN   = 3'd1,
      REG_SECOND_DELAY = 3'd2,
      REG_SECOND_GAIN  = 3'd3,
      REG_THIRD_DELAY  = 3'd4,
      REG_THIRD_GAIN   = 3'd5
   } reg_index_type;

   // reverb preset at 44.1 kHz: 100/250/500 ms, gains 0.75/0.35/0.15
   localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 15'd4410;
   localparam logic [GAIN_W-1:0]  FIRST_GAIN_RST   = 15'd24576;
   localparam logic [DELAY_W-1:0] SECOND_DELAY_RST = 15'd11025;
   localparam logic [GAIN_W-1:0]  SECOND_GAIN_RST  = 15'd11469;
   localparam logic [DELAY_W-1:0] THIRD_DELAY_RST  = 15'd22050;
   localparam logic [GAIN_W-1:0]  THIRD_GAIN_RST   = 15'd4915;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // position of an item in the delay lines, carried down the pipeline
   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  ch;
      logic [POS_W-1:0] pos;
      logic             wrapped;
   } tag_type;

   // clamp a widened sum to the sample range
   function automatic sample_type sat_sample(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((1 <<< (SAMPLE_W - 1)) - 1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return sample_type'(hi[SAMPLE_W-1:0]);
      end else if (v < lo) begin
         return sample_type'(lo[SAMPLE_W-1:0]);
      end
      return sample_type'(v[SAMPLE_W-1:0]);
   endfunction

endpackage

// File: sv/cfc_comb_stage.sv
// ----------------------------------------------------------------------------
// cfc_comb_stage
// One feedback comb stage: y = sat(x + round(g * y[n-D])). Holds the delay
// line memory of both channels, reads it in the cycle before the compute
// cycle and bypasses the value being written in the same cycle.
// ----------------------------------------------------------------------------
module cfc_comb_stage (
   input  logic                          clock,
   input  cfc_pkg::tag_type              rd_tag,
   input  logic [cfc_pkg::DELAY_W-1:0]   delay,
   input  logic [cfc_pkg::GAIN_W-1:0]    gain,
   input  cfc_pkg::tag_type              cur_tag,
   input  cfc_pkg::sample_type           cur_x,
   input  cfc_pkg::sample_type           prev_y,
   output cfc_pkg::sample_type           y
);

   cfc_pkg::sample_type line_mem [cfc_pkg::MEM_DEPTH];

   cfc_pkg::sample_type                 rdata_ff;
   logic                                fwd_ff;
   logic                                empty_ff;
   logic [cfc_pkg::POS_W-1:0]           rd_idx;
   logic [cfc_pkg::ADDR_W-1:0]          raddr;
   logic [cfc_pkg::ADDR_W-1:0]          waddr;
   logic                                fwd_in;
   logic                                empty_in;
   cfc_pkg::sample_type                 operand;
   logic signed [cfc_pkg::PROD_W-1:0]   prod;
   logic signed [cfc_pkg::PROD_W-1:0]   rounded;
   logic signed [cfc_pkg::TERM_W-1:0]   term;
   logic signed [cfc_pkg::SUM_W-1:0]    sum;

   // read slot D behind the item's write slot, wraps within the channel
   assign rd_idx = rd_tag.pos - cfc_pkg::POS_W'(delay);
   assign raddr  = {rd_tag.ch, rd_idx};
   assign waddr  = {cur_tag.ch, cur_tag.pos};

   // the item ahead writes this slot at the same edge
   assign fwd_in = cur_tag.valid && (cur_tag.ch == rd_tag.ch) && (cur_tag.pos == rd_idx);

   // slot not yet written since reset reads as zero
   assign empty_in = !rd_tag.wrapped && (rd_idx >= rd_tag.pos);

   // delay line memory, read data registered
   always_ff @(posedge clock) begin
      if (cur_tag.valid) begin
         line_mem[waddr] <= y;
      end
      rdata_ff <= line_mem[raddr];
      fwd_ff   <= fwd_in;
      empty_ff <= empty_in;
   end

   // feedback operand select
   always_comb begin
      if (fwd_ff) begin
         operand = prev_y;
      end else if (empty_ff) begin
         operand = '0;
      end else begin
         operand = rdata_ff;
      end
   end

   // scale, round half up, add and clamp
   assign prod    = operand * $signed({1'b0, gain});
   assign rounded = prod + cfc_pkg::ROUND_HALF;
   assign term    = rounded[cfc_pkg::PROD_W-1:cfc_pkg::GAIN_W];
   assign sum     = cfc_pkg::SUM_W'(term) + cfc_pkg::SUM_W'(cur_x);
   assign y       = cfc_pkg::sat_sample(sum);

endmodule

// File: sv/cascaded_feedback_comb_echo_unit.sv
// ----------------------------------------------------------------------------
// cascaded_feedback_comb_echo_unit
// Three cascaded feedback comb stages on a two-channel 16-bit sample stream.
// ----------------------------------------------------------------------------
// Takes one sample per clock while req_stall is low and returns one processed
// sample per accepted item, in order. Each stage keeps a 32768-sample delay
// line per channel in its own single-port-write, one-read memory; the stage
// loop (registered read or bypass of the slot written in the same cycle,
// multiply, round, add, saturate) is combinational up to the next pipeline
// register, which is what allows a delay of one sample at full rate. Up to
// eight items may be outstanding; beyond that req_stall
// rises until results are taken. No clearing pass is needed after reset: a
// per-channel write position and wrap flag make slots not yet written read as
// zero. Configuration is taken every cycle (csr_ready is always high); writes
// to indexes past the third gain are ignored.
// ----------------------------------------------------------------------------
module cascaded_feedback_comb_echo_unit (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_channel,
   input  logic signed [15:0]               req_sample_in,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_channel_out,
   output logic signed [15:0]               rsp_sample_out,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [14:0]                      csr_data
);

   localparam int PIPE_LAST = cfc_pkg::NUM_STAGES + 1;

   // configuration
   logic [cfc_pkg::DELAY_W-1:0] delay_ff [cfc_pkg::NUM_STAGES];
   logic [cfc_pkg::GAIN_W-1:0]  gain_ff  [cfc_pkg::NUM_STAGES];

   // per-channel write position and wrap flag
   logic [cfc_pkg::POS_W-1:0]   wp_ff      [cfc_pkg::CHANNELS];
   logic                        wrapped_ff [cfc_pkg::CHANNELS];

   // pipeline
   cfc_pkg::tag_type            tag_ff [PIPE_LAST+1];
   cfc_pkg::sample_type         y_ff   [PIPE_LAST+1];
   cfc_pkg::sample_type         stage_y [cfc_pkg::NUM_STAGES];

   // result queue
   cfc_pkg::sample_type             fifo_y_ff  [cfc_pkg::FIFO_DEPTH];
   logic [cfc_pkg::CH_W-1:0]        fifo_ch_ff [cfc_pkg::FIFO_DEPTH];
   logic [cfc_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [cfc_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [cfc_pkg::FIFO_CNT_W-1:0]  count_ff;
   logic [cfc_pkg::FIFO_CNT_W-1:0]  count_in;
   logic [cfc_pkg::FIFO_CNT_W-1:0]  occ_ff;
   logic [cfc_pkg::FIFO_CNT_W-1:0]  occ_in;

   logic                        accept;
   logic                        push;
   logic                        pop;
   logic [cfc_pkg::CH_W-1:0]    in_ch;

   // handshakes
   assign in_ch     = req_channel;
   assign accept    = req_valid && !req_stall;
   assign push      = tag_ff[PIPE_LAST].valid;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (occ_ff == cfc_pkg::FIFO_CNT_W'(cfc_pkg::FIFO_DEPTH));
   assign rsp_valid = (count_ff != '0);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff[0] <= cfc_pkg::FIRST_DELAY_RST;
         gain_ff[0]  <= cfc_pkg::FIRST_GAIN_RST;
         delay_ff[1] <= cfc_pkg::SECOND_DELAY_RST;
         gain_ff[1]  <= cfc_pkg::SECOND_GAIN_RST;
         delay_ff[2] <= cfc_pkg::THIRD_DELAY_RST;
         gain_ff[2]  <= cfc_pkg::THIRD_GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (cfc_pkg::reg_index_type'(csr_index))
            cfc_pkg::REG_FIRST_DELAY:  delay_ff[0] <= csr_data;
            cfc_pkg::REG_FIRST_GAIN:   gain_ff[0]  <= csr_data;
            cfc_pkg::REG_SECOND_DELAY: delay_ff[1] <= csr_data;
            cfc_pkg::REG_SECOND_GAIN:  gain_ff[1]  <= csr_data;
            cfc_pkg::REG_THIRD_DELAY:  delay_ff[2] <= csr_data;
            cfc_pkg::REG_THIRD_GAIN:   gain_ff[2]  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // write position advance per channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < cfc_pkg::CHANNELS; c++) begin
            wp_ff[c]      <= '0;
            wrapped_ff[c] <= 1'b0;
         end
      end else if (accept) begin
         wp_ff[in_ch] <= wp_ff[in_ch] + cfc_pkg::POS_W'(1);
         if (wp_ff[in_ch] == '1) begin
            wrapped_ff[in_ch] <= 1'b1;
         end
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PIPE_LAST; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[0].valid   <= accept;
         tag_ff[0].ch      <= in_ch;
         tag_ff[0].pos     <= wp_ff[in_ch];
         tag_ff[0].wrapped <= wrapped_ff[in_ch];
         for (int k = 1; k <= PIPE_LAST; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // pipeline samples: raw input, then each stage's output
   always_ff @(posedge clock) begin
      y_ff[0] <= req_sample_in;
      y_ff[1] <= y_ff[0];
      for (int k = 0; k < cfc_pkg::NUM_STAGES; k++) begin
         y_ff[k+2] <= stage_y[k];
      end
   end

   // comb stages: stage k reads with the item one step ahead of its compute
   for (genvar k = 0; k < cfc_pkg::NUM_STAGES; k++) begin : g_stage
      cfc_comb_stage u_stage (
         .clock   (clock),
         .rd_tag  (tag_ff[k]),
         .delay   (delay_ff[k]),
         .gain    (gain_ff[k]),
         .cur_tag (tag_ff[k+1]),
         .cur_x   (y_ff[k+1]),
         .prev_y  (y_ff[k+2]),
         .y       (stage_y[k])
      );
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_y_ff[wr_ptr_ff]  <= y_ff[PIPE_LAST];
         fifo_ch_ff[wr_ptr_ff] <= tag_ff[PIPE_LAST].ch;
      end
   end

   // queue fill and outstanding item counts
   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_in + cfc_pkg::FIFO_CNT_W'(1);
      end
      if (pop) begin
         count_in = count_in - cfc_pkg::FIFO_CNT_W'(1);
      end
      occ_in = occ_ff;
      if (accept) begin
         occ_in = occ_in + cfc_pkg::FIFO_CNT_W'(1);
      end
      if (pop) begin
         occ_in = occ_in - cfc_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cfc_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cfc_pkg::FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
         occ_ff   <= occ_in;
      end
   end

   // result outputs
   assign rsp_channel_out = fifo_ch_ff[rd_ptr_ff];
   assign rsp_sample_out  = fifo_y_ff[rd_ptr_ff];

endmodule
